FILE: rtl/cts_pkg.sv
package cts_pkg;

  // Default sizing of the slot table
  localparam int TASK_SLOTS_DEF   = 16;
  localparam int PENDING_BITS_DEF = 8;

  // Most tasks named by one dispatch
  localparam int MAX_RESULTS = 16;

  // Field widths of the channels
  localparam int OP_W     = 2;
  localparam int TAG_W    = 8;
  localparam int TIME_W   = 32;
  localparam int SLOTNO_W = 4;

  // Operation codes on the input channel
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } opcode_t;

  // Kind of slot update applied by the update unit
  typedef enum logic {
    UPD_TICK     = 1'b0,
    UPD_DISPATCH = 1'b1
  } upd_op_t;

  // Status of a slot update, back to the sequencer
  typedef struct packed {
    logic pend_nz;    // pending count nonzero after the update
    logic free_slot;  // one-shot task ran, release the slot
  } upd_stat_t;

endpackage

FILE: rtl/cts_chan_if.sv
interface cts_in_if
  import cts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [TAG_W-1:0]    task_tag;
  logic [TIME_W-1:0]   first_delay;
  logic [TIME_W-1:0]   repeat_period;
  logic [SLOTNO_W-1:0] slot_number;

  modport source (output valid, opcode, task_tag, first_delay, repeat_period, slot_number,
                  input ready);
  modport sink   (input valid, opcode, task_tag, first_delay, repeat_period, slot_number,
                  output ready);
endinterface

interface cts_out_if
  import cts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                status;
  logic [SLOTNO_W-1:0] slot_used;
  logic [TAG_W-1:0]    run_tag;
  logic                run_valid;
  logic                last;

  modport source (output valid, status, slot_used, run_tag, run_valid, last,
                  input ready);
  modport sink   (input valid, status, slot_used, run_tag, run_valid, last,
                  output ready);
endinterface

FILE: rtl/cts_ram.sv
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cts_upd.sv
module cts_upd
  import cts_pkg::*;
#(
  parameter int PENDING_BITS = PENDING_BITS_DEF
) (
  input  upd_op_t                 op,
  input  logic [TIME_W-1:0]       delay,
  input  logic [TIME_W-1:0]       period,
  input  logic [PENDING_BITS-1:0] pend,
  output logic [TIME_W-1:0]       delay_nxt,
  output logic [PENDING_BITS-1:0] pend_nxt,
  output upd_stat_t               stat
);

  logic pend_max;

  assign pend_max = &pend;

  // Count down or reload the delay, bump or consume pending runs
  always_comb begin
    delay_nxt      = delay;
    pend_nxt       = pend;
    stat.free_slot = 1'b0;
    unique case (op)
      UPD_TICK: begin
        if (delay == '0) begin
          if (!pend_max) begin
            pend_nxt = pend + PENDING_BITS'(1);
          end
          if (period != '0) begin
            delay_nxt = period;
          end
        end else begin
          delay_nxt = delay - TIME_W'(1);
        end
      end
      UPD_DISPATCH: begin
        pend_nxt       = pend - PENDING_BITS'(1);
        stat.free_slot = (period == '0);
      end
      default: begin
        pend_nxt = pend;
      end
    endcase
    stat.pend_nz = (pend_nxt != '0);
  end

endmodule

FILE: rtl/cooperative_task_scheduler.sv
// Time-triggered cooperative scheduler over a table of TASK_SLOTS slots whose records
// (tag, delay, period, pending count) sit in one single-port-write, single-port-read RAM;
// valid and ready-to-run marks per slot are flip-flops cleared by reset, so no clearing
// pass runs after reset. One item is worked at a time and is accepted only while the
// sequencer is idle; a result may still wait in the output register meanwhile. Add and
// delete each pass through one result state. Tick streams every slot through the RAM
// read port and writes each valid slot back in the following cycle. Dispatch scans
// one slot a cycle while none is named; each slot it names takes an extra state that
// waits for the result register, at most MAX_RESULTS tasks per dispatch. A stalled
// result register adds its wait.
module cooperative_task_scheduler
  import cts_pkg::*;
#(
  parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
  parameter int PENDING_BITS = PENDING_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cts_in_if.sink    in_chan,
  cts_out_if.source out_chan
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int REC_W  = TAG_W + 2 * TIME_W + PENDING_BITS;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TICK   = 6'b000010,
    S_SINGLE = 6'b000100,
    S_DSCAN  = 6'b001000,
    S_DEMIT  = 6'b010000,
    S_DFIN   = 6'b100000
  } state_t;

  // Control registers
  state_t            state_r, state_nxt;
  logic [SLOT_W:0]   cur_r, cur_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TASK_SLOTS-1:0] valid_r, valid_nxt;
  logic [TASK_SLOTS-1:0] ready_r, ready_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  opcode_t             op_r;
  logic [TAG_W-1:0]    tag_r;
  logic [TIME_W-1:0]   delay_in_r;
  logic [TIME_W-1:0]   period_in_r;
  logic [SLOTNO_W-1:0] slotn_r;
  logic                out_status_r, out_status_nxt;
  logic [SLOTNO_W-1:0] out_slot_r, out_slot_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                out_run_r, out_run_nxt;
  logic                out_last_r, out_last_nxt;

  // Memory port
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [REC_W-1:0]  mem_wdata, mem_rdata;

  // Record fields read back
  logic [TAG_W-1:0]        rd_tag;
  logic [TIME_W-1:0]       rd_delay, rd_period;
  logic [PENDING_BITS-1:0] rd_pend;

  // Update unit
  upd_op_t                 upd_op;
  logic [TIME_W-1:0]       upd_delay;
  logic [PENDING_BITS-1:0] upd_pend;
  upd_stat_t               upd_stat;

  // Misc decode
  logic                     in_fire, out_free, load_out;
  logic                     cur_done;
  logic [SLOT_W-1:0]        cur_idx;
  logic [SLOT_W+SLOTNO_W-1:0] cur_ext, free_ext, del_ext;
  logic [SLOT_W-1:0]        free_idx, del_idx;
  logic                     free_found, del_in_range;
  logic [TASK_SLOTS-1:0]    above_mask;
  logic                     disp_last;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign cur_done = (cur_r == (SLOT_W+1)'(TASK_SLOTS));
  assign cur_idx  = cur_r[SLOT_W-1:0];

  assign rd_tag    = mem_rdata[REC_W-1 -: TAG_W];
  assign rd_delay  = mem_rdata[REC_W-TAG_W-1 -: TIME_W];
  assign rd_period = mem_rdata[PENDING_BITS +: TIME_W];
  assign rd_pend   = mem_rdata[PENDING_BITS-1:0];

  assign cur_ext      = {{SLOTNO_W{1'b0}}, cur_idx};
  assign free_ext     = {{SLOTNO_W{1'b0}}, free_idx};
  assign del_ext      = {{SLOT_W{1'b0}}, slotn_r};
  assign del_idx      = del_ext[SLOT_W-1:0];
  assign del_in_range = (del_ext < (SLOT_W+SLOTNO_W)'(TASK_SLOTS));

  cts_ram #(
    .WIDTH (REC_W),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cts_upd #(
    .PENDING_BITS (PENDING_BITS)
  ) u_upd (
    .op        (upd_op),
    .delay     (rd_delay),
    .period    (rd_period),
    .pend      (rd_pend),
    .delay_nxt (upd_delay),
    .pend_nxt  (upd_pend),
    .stat      (upd_stat)
  );

  // Find the lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // Mark slots above the scan cursor, to spot the final run of a dispatch
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      above_mask[i] = (SLOT_W'(i) > cur_idx);
    end
  end

  assign disp_last = (cnt_r == CNT_W'(MAX_RESULTS - 1)) || !(|(ready_r & above_mask));

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    rd_pend_nxt = rd_pend_r;
    rd_slot_nxt = rd_slot_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    ready_nxt   = ready_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    upd_op      = UPD_TICK;
    load_out       = 1'b0;
    out_status_nxt = 1'b0;
    out_slot_nxt   = '0;
    out_tag_nxt    = '0;
    out_run_nxt    = 1'b0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        cur_nxt     = '0;
        cnt_nxt     = '0;
        rd_pend_nxt = 1'b0;
        if (in_fire) begin
          unique case (opcode_t'(in_chan.opcode))
            OP_TICK:     state_nxt = S_TICK;
            OP_ADD:      state_nxt = S_SINGLE;
            OP_DELETE:   state_nxt = S_SINGLE;
            OP_DISPATCH: state_nxt = S_DSCAN;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end

      // Stream reads; write back the valid slot read in the previous cycle
      S_TICK: begin
        upd_op = UPD_TICK;
        if (!cur_done) begin
          mem_re      = 1'b1;
          mem_raddr   = cur_idx;
          cur_nxt     = cur_r + (SLOT_W+1)'(1);
          rd_pend_nxt = 1'b1;
          rd_slot_nxt = cur_idx;
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r && valid_r[rd_slot_r]) begin
          mem_we               = 1'b1;
          mem_waddr            = rd_slot_r;
          mem_wdata            = {rd_tag, upd_delay, rd_period, upd_pend};
          ready_nxt[rd_slot_r] = upd_stat.pend_nz;
        end
        if (cur_done && !rd_pend_r) begin
          state_nxt = S_SINGLE;
        end
      end

      // Single-beat result: add, delete, or end of tick
      S_SINGLE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_ADD: begin
              if (free_found) begin
                mem_we              = 1'b1;
                mem_waddr           = free_idx;
                mem_wdata           = {tag_r, delay_in_r, period_in_r, {PENDING_BITS{1'b0}}};
                valid_nxt[free_idx] = 1'b1;
                ready_nxt[free_idx] = 1'b0;
                out_slot_nxt        = free_ext[SLOTNO_W-1:0];
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            OP_DELETE: begin
              out_slot_nxt = slotn_r;
              if (del_in_range) begin
                valid_nxt[del_idx] = 1'b0;
                ready_nxt[del_idx] = 1'b0;
              end
            end
            default: begin
              out_slot_nxt = '0;
            end
          endcase
        end
      end

      // Skip idle slots, fetch the next one with pending runs
      S_DSCAN: begin
        if (cur_done || (cnt_r == CNT_W'(MAX_RESULTS))) begin
          state_nxt = S_DFIN;
        end else if (ready_r[cur_idx]) begin
          mem_re    = 1'b1;
          mem_raddr = cur_idx;
          state_nxt = S_DEMIT;
        end else begin
          cur_nxt = cur_r + (SLOT_W+1)'(1);
        end
      end

      // Name the task, consume one run, free a one-shot slot
      S_DEMIT: begin
        upd_op = UPD_DISPATCH;
        if (out_free) begin
          load_out     = 1'b1;
          out_slot_nxt = cur_ext[SLOTNO_W-1:0];
          out_tag_nxt  = rd_tag;
          out_run_nxt  = 1'b1;
          out_last_nxt = disp_last;
          mem_we       = 1'b1;
          mem_waddr    = cur_idx;
          mem_wdata    = {rd_tag, rd_delay, rd_period, upd_pend};
          if (upd_stat.free_slot) begin
            valid_nxt[cur_idx] = 1'b0;
            ready_nxt[cur_idx] = 1'b0;
          end else begin
            ready_nxt[cur_idx] = upd_stat.pend_nz;
          end
          cnt_nxt   = cnt_r + CNT_W'(1);
          cur_nxt   = cur_r + (SLOT_W+1)'(1);
          state_nxt = S_DSCAN;
        end
      end

      // End of dispatch: send the empty result when nothing was named
      S_DFIN: begin
        if (cnt_r != '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_slot_r   <= '0;
      cnt_r       <= '0;
      valid_r     <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_slot_r   <= rd_slot_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input beat and the result beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= opcode_t'(in_chan.opcode);
      tag_r       <= in_chan.task_tag;
      delay_in_r  <= in_chan.first_delay;
      period_in_r <= in_chan.repeat_period;
      slotn_r     <= in_chan.slot_number;
    end
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_tag_r    <= out_tag_nxt;
      out_run_r    <= out_run_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.slot_used = out_slot_r;
  assign out_chan.run_tag   = out_tag_r;
  assign out_chan.run_valid = out_run_r;
  assign out_chan.last      = out_last_r;

`ifndef SYNTHESIS
  a_ready_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r & ~valid_r) == '0)
    else $error("slot marked ready while free");

  a_rw_split: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same slot in one cycle");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("dispatch named too many tasks");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result register overwritten before taken");
`endif

endmodule

FILE: test/tb_cooperative_task_scheduler.sv
module tb_cooperative_task_scheduler;
  import cts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = TASK_SLOTS_DEF;
  localparam int PBITS = PENDING_BITS_DEF;
  localparam logic [PBITS-1:0] PEND_MAX = '1;
  localparam int RANDOM_ITEMS = 76;
  localparam int DRAIN_CYCLES = NSLOT + MAX_RESULTS + 16;
  localparam int PRESSURE_CYCLES = 250;
  localparam longint WATCHDOG_NS = 64'd8_000_000;

  // One input beat as the scheduler sees it
  typedef struct packed {
    opcode_t               op;
    logic [TAG_W-1:0]      tag;
    logic [TIME_W-1:0]     dly;
    logic [TIME_W-1:0]     per;
    logic [SLOTNO_W-1:0]   slot;
  } sched_cmd_t;

  // One result beat
  typedef struct packed {
    logic                  status;
    logic [SLOTNO_W-1:0]   slot;
    logic [TAG_W-1:0]      tag;
    logic                  run;
    logic                  last;
  } sched_res_t;

  // Directed row: command, repeat count, and a typed result where one is obvious
  typedef struct packed {
    sched_cmd_t            cmd;
    int unsigned           reps;
    bit                    typed;
    sched_res_t            want;
  } walk_row_t;

  localparam sched_res_t RES_DONE = '{1'b0, 4'd0, 8'h00, 1'b0, 1'b1};
  localparam sched_res_t RES_FULL = '{1'b1, 4'd0, 8'h00, 1'b0, 1'b1};

  localparam int WALK_ROWS = 21;
  localparam walk_row_t WALK [WALK_ROWS] = '{
    // tick and dispatch on an empty table
    '{'{OP_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1, RES_DONE},
    '{'{OP_DISPATCH, 8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1, RES_DONE},
    // delete of a free slot at the top of the table
    '{'{OP_DELETE,   8'h00, 32'h0000_0000, 32'h0000_0000, 4'd15}, 1, 1'b1,
      '{1'b0, 4'd15, 8'h00, 1'b0, 1'b1}},
    // adds: one-shot, period one, extreme delay and period, short one-shot
    '{'{OP_ADD,      8'hFF, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1,
      '{1'b0, 4'd0, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ADD,      8'h00, 32'h0000_0000, 32'h0000_0001, 4'd0},  1, 1'b1,
      '{1'b0, 4'd1, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ADD,      8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0},  1, 1'b1,
      '{1'b0, 4'd2, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ADD,      8'h5A, 32'h0000_0002, 32'h0000_0000, 4'd0},  1, 1'b1,
      '{1'b0, 4'd3, 8'h00, 1'b0, 1'b1}},
    '{'{OP_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1, RES_DONE},
    '{'{OP_DISPATCH, 8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b0, RES_DONE},
    '{'{OP_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  3, 1'b1, RES_DONE},
    '{'{OP_DISPATCH, 8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b0, RES_DONE},
    // fill every free slot, then one add too many
    '{'{OP_ADD,      8'h3C, 32'h0000_0000, 32'h0000_0000, 4'd0}, 14, 1'b0, RES_DONE},
    '{'{OP_ADD,      8'hC3, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1, RES_FULL},
    '{'{OP_DELETE,   8'h00, 32'h0000_0000, 32'h0000_0000, 4'd2},  1, 1'b1,
      '{1'b0, 4'd2, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ADD,      8'h81, 32'h0000_0000, 32'h0000_0007, 4'd0},  1, 1'b1,
      '{1'b0, 4'd2, 8'h00, 1'b0, 1'b1}},
    // run pending counts into saturation, then a dispatch that names every slot
    '{'{OP_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0}, 260, 1'b1, RES_DONE},
    '{'{OP_DISPATCH, 8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b0, RES_DONE},
    '{'{OP_DISPATCH, 8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b0, RES_DONE},
    '{'{OP_DELETE,   8'h00, 32'h0000_0000, 32'h0000_0000, 4'd1},  1, 1'b1,
      '{1'b0, 4'd1, 8'h00, 1'b0, 1'b1}},
    '{'{OP_DELETE,   8'h00, 32'h0000_0000, 32'h0000_0000, 4'd0},  1, 1'b1,
      '{1'b0, 4'd0, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ADD,      8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0},  1, 1'b0, RES_DONE}
  };

  logic clk = 1'b0;
  logic rst_n;

  cts_in_if  in_if ();
  cts_out_if out_if ();

  cooperative_task_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Scheduler table as the block should hold it
  bit                 tbl_valid   [NSLOT];
  logic [TAG_W-1:0]   tbl_tag     [NSLOT];
  logic [TIME_W-1:0]  tbl_delay   [NSLOT];
  logic [TIME_W-1:0]  tbl_period  [NSLOT];
  logic [PBITS-1:0]   tbl_pending [NSLOT];

  // Results of the latest command and results still owed by the block
  sched_res_t step_res [MAX_RESULTS];
  int         step_count;
  sched_res_t owed_results [$];

  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_entry(input int s);
    tbl_valid[s]   = 1'b0;
    tbl_tag[s]     = '0;
    tbl_delay[s]   = '0;
    tbl_period[s]  = '0;
    tbl_pending[s] = '0;
  endtask

  task automatic add_step(input logic st, input logic [SLOTNO_W-1:0] sl,
                          input logic [TAG_W-1:0] tg, input logic rv, input logic lst);
    step_res[step_count] = '{st, sl, tg, rv, lst};
    step_count++;
  endtask

  // Apply one command to the table and collect the results it causes
  task automatic schedule_cmd(input sched_cmd_t c);
    int free_at;
    free_at = -1;
    step_count = 0;
    case (c.op)
      OP_TICK: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_delay[s] == '0) begin
              if (tbl_pending[s] != PEND_MAX) tbl_pending[s] = tbl_pending[s] + 1'b1;
              if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
            end else begin
              tbl_delay[s] = tbl_delay[s] - 1'b1;
            end
          end
        end
        add_step(1'b0, '0, '0, 1'b0, 1'b1);
      end
      OP_ADD: begin
        for (int s = NSLOT - 1; s >= 0; s--) begin
          if (!tbl_valid[s]) free_at = s;
        end
        if (free_at < 0) begin
          add_step(1'b1, '0, '0, 1'b0, 1'b1);
        end else begin
          tbl_valid[free_at]   = 1'b1;
          tbl_tag[free_at]     = c.tag;
          tbl_delay[free_at]   = c.dly;
          tbl_period[free_at]  = c.per;
          tbl_pending[free_at] = '0;
          add_step(1'b0, SLOTNO_W'(free_at), '0, 1'b0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (int'(c.slot) < NSLOT) clear_entry(int'(c.slot));
        add_step(1'b0, c.slot, '0, 1'b0, 1'b1);
      end
      default: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (step_count < MAX_RESULTS && tbl_valid[s] && tbl_pending[s] != '0) begin
            add_step(1'b0, SLOTNO_W'(s), tbl_tag[s], 1'b1, 1'b0);
            tbl_pending[s] = tbl_pending[s] - 1'b1;
            if (tbl_period[s] == '0) clear_entry(s);
          end
        end
        if (step_count == 0) begin
          add_step(1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          step_res[step_count-1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one beat from a falling edge, hold it until taken, return on the next falling edge
  task automatic send_cmd(input sched_cmd_t c, input bit typed, input sched_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= c.op;
    in_if.task_tag      <= c.tag;
    in_if.first_delay   <= c.dly;
    in_if.repeat_period <= c.per;
    in_if.slot_number   <= c.slot;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    schedule_cmd(c);
    if (typed) begin
      owed_results.push_back(want);
    end else begin
      for (int i = 0; i < step_count; i++) owed_results.push_back(step_res[i]);
    end
    @(negedge clk);
  endtask

  // Random command: mostly short delays and periods so tasks fire, some extremes
  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int roll;
    roll   = $urandom_range(99);
    c.tag  = TAG_W'($urandom());
    c.dly  = $urandom();
    c.per  = $urandom();
    c.slot = SLOTNO_W'($urandom());
    if (roll < 35) begin
      c.op = OP_TICK;
    end else if (roll < 60) begin
      c.op = OP_ADD;
      roll = $urandom_range(99);
      if (roll < 88) c.dly = $urandom_range(0, 6);
      else if (roll < 94) c.dly = '1;
      roll = $urandom_range(99);
      if (roll < 30) c.per = '0;
      else if (roll < 85) c.per = $urandom_range(1, 8);
      else if (roll < 92) c.per = '1;
    end else if (roll < 75) begin
      c.op = OP_DELETE;
    end else begin
      c.op = OP_DISPATCH;
    end
    return c;
  endfunction

  // Drive result ready: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest owed result
  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        log_mismatch($sformatf("result beat with nothing owed: slot %0d tag %02h",
                               out_if.slot_used, out_if.run_tag));
      end else begin
        want = owed_results.pop_front();
        if (out_if.status !== want.status)
          log_mismatch($sformatf("status %b, want %b", out_if.status, want.status));
        if (out_if.slot_used !== want.slot)
          log_mismatch($sformatf("slot_used %0d, want %0d", out_if.slot_used, want.slot));
        if (out_if.run_tag !== want.tag)
          log_mismatch($sformatf("run_tag %02h, want %02h", out_if.run_tag, want.tag));
        if (out_if.run_valid !== want.run)
          log_mismatch($sformatf("run_valid %b, want %b", out_if.run_valid, want.run));
        if (out_if.last !== want.last)
          log_mismatch($sformatf("last %b, want %b", out_if.last, want.last));
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int idle_of [4];
    int stall_of [4];
    idle_of  = '{0, 59, 0, 15};
    stall_of = '{0, 0, 59, 15};

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_TICK;
    in_if.task_tag      = '0;
    in_if.first_delay   = '0;
    in_if.repeat_period = '0;
    in_if.slot_number   = '0;
    out_if.ready        = 1'b0;
    for (int s = 0; s < NSLOT; s++) clear_entry(s);

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int r = 0; r < WALK_ROWS; r++) begin
      for (int n = 0; n < int'(WALK[r].reps); n++) begin
        send_cmd(WALK[r].cmd, WALK[r].typed, WALK[r].want);
      end
    end

    // Random traffic over four phases of sender idling and receiver stalls; hold off the receiver at the start
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_of[p];
      stall_pct     = stall_of[p];
      if (p == 0) hold_left = PRESSURE_CYCLES;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        send_cmd(rand_cmd(), 1'b0, RES_DONE);
      end
    end
    in_if.valid <= 1'b0;

    // Drain everything owed, then let the block settle
    stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
